FILE: hw/rtl/dfsec_pkg.sv
`default_nettype none
//------------------------------------------------------------------------------
// dfsec_pkg
// Shared types, widths and codes for the depth-first edge classifier.
//------------------------------------------------------------------------------
package dfsec_pkg;

   // Number of graph vertices that the search walks (2 to 8).
   localparam int VERTICES = 8;

   // Field widths fixed by the word formats.
   localparam int OP_W    = 2;
   localparam int VID_W   = 3;
   localparam int ROW_W   = 8;
   localparam int KIND_W  = 2;
   localparam int STAMP_W = 4;
   localparam int TIME_W  = 5;

   // Storage slots addressed by a vertex index, and a count wide enough to hold them.
   localparam int SLOTS  = 1 << VID_W;
   localparam int CNT_W  = VID_W + 1;

   localparam logic [CNT_W-1:0] VERTEX_COUNT = CNT_W'(VERTICES);
   localparam logic [CNT_W-1:0] STACK_SLOTS  = CNT_W'(SLOTS);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TREE    = 2'd0,
      KIND_BACK    = 2'd1,
      KIND_FORWARD = 2'd2,
      KIND_CROSS   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      COLOR_UNSEEN = 2'd0,
      COLOR_ACTIVE = 2'd1,
      COLOR_DONE   = 2'd2
   } color_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROOT  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_row;
      logic start_run;
      logic latch_read;
      logic root_skip;
      logic root_push;
      logic pop;
      logic step;
      logic flush;
      logic read_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic roots_done;
      logic root_seen;
      logic stack_empty;
      logic scan_end;
      logic edge_hit;
      logic held_valid;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/dfsec_req_if.sv
`default_nettype none
//------------------------------------------------------------------------------
// dfsec_req_if
// Request channel: load a row, run the search or read one vertex.
//------------------------------------------------------------------------------
interface dfsec_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [2:0] vertex_index;
   logic [7:0] row_bits;

   modport source (output valid, output op, output vertex_index, output row_bits,
                   input ready);
   modport sink   (input valid, input op, input vertex_index, input row_bits,
                   output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dfsec_rsp_if.sv
`default_nettype none
//------------------------------------------------------------------------------
// dfsec_rsp_if
// Response channel: classified edge records and vertex read responses.
//------------------------------------------------------------------------------
interface dfsec_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] from_vertex;
   logic [2:0] to_vertex;
   logic [1:0] edge_kind;
   logic [2:0] parent_vertex;
   logic       has_parent;
   logic [3:0] discover_time;
   logic [3:0] finish_time;
   logic       is_vertex_info;
   logic       last;

   modport source (output valid, output from_vertex, output to_vertex, output edge_kind,
                   output parent_vertex, output has_parent, output discover_time,
                   output finish_time, output is_vertex_info, output last,
                   input ready);
   modport sink   (input valid, input from_vertex, input to_vertex, input edge_kind,
                   input parent_vertex, input has_parent, input discover_time,
                   input finish_time, input is_vertex_info, input last,
                   output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dfsec_ctrl.sv
`default_nettype none
//------------------------------------------------------------------------------
// dfsec_ctrl
// Controller state machine that sequences loads, searches and reads.
//------------------------------------------------------------------------------
module dfsec_ctrl
   import dfsec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [OP_W-1:0]   req_op,
   output logic              req_ready,
   input  status_type        sts,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_LOAD: begin
                     cmd.load_row = 1'b1;
                  end
                  OP_RUN: begin
                     cmd.start_run = 1'b1;
                     state_in      = ST_ROOT;
                  end
                  OP_READ: begin
                     cmd.latch_read = 1'b1;
                     state_in       = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROOT: begin
            if (sts.roots_done) begin
               state_in = ST_FLUSH;
            end else if (sts.root_seen) begin
               cmd.root_skip = 1'b1;
            end else begin
               cmd.root_push = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.stack_empty) begin
               state_in = ST_ROOT;
            end else if (sts.scan_end) begin
               cmd.pop = 1'b1;
            end else if (!(sts.edge_hit && sts.held_valid && !sts.out_free)) begin
               // A new edge may only displace the held record once the output is free.
               cmd.step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!sts.held_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            if (sts.out_free) begin
               cmd.read_emit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/dfsec_datapath.sv
`default_nettype none
//------------------------------------------------------------------------------
// dfsec_datapath
// Graph storage, vertex records, walk stack, held edge and output register.
//------------------------------------------------------------------------------
module dfsec_datapath
   import dfsec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic [VID_W-1:0]   req_vertex_index,
   input  logic [ROW_W-1:0]   req_row_bits,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [VID_W-1:0]   rsp_from_vertex,
   output logic [VID_W-1:0]   rsp_to_vertex,
   output logic [KIND_W-1:0]  rsp_edge_kind,
   output logic [VID_W-1:0]   rsp_parent_vertex,
   output logic               rsp_has_parent,
   output logic [STAMP_W-1:0] rsp_discover_time,
   output logic [STAMP_W-1:0] rsp_finish_time,
   output logic               rsp_is_vertex_info,
   output logic               rsp_last
);

   logic [ROW_W-1:0]   adj_ff    [SLOTS];
   color_type          color_ff  [SLOTS];
   logic [VID_W-1:0]   parent_ff [SLOTS];
   logic               has_par_ff[SLOTS];
   logic [STAMP_W-1:0] disc_ff   [SLOTS];
   logic [STAMP_W-1:0] fin_ff    [SLOTS];
   logic [VID_W-1:0]   stk_vtx_ff[SLOTS];
   logic [CNT_W-1:0]   stk_nxt_ff[SLOTS];
   logic [CNT_W-1:0]   depth_ff;
   logic [CNT_W-1:0]   root_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [VID_W-1:0]   rd_vtx_ff;

   logic               held_valid_ff;
   logic [VID_W-1:0]   held_from_ff;
   logic [VID_W-1:0]   held_to_ff;
   kind_type           held_kind_ff;

   logic               out_valid_ff;
   logic [VID_W-1:0]   out_from_ff;
   logic [VID_W-1:0]   out_to_ff;
   logic [KIND_W-1:0]  out_kind_ff;
   logic [VID_W-1:0]   out_parent_ff;
   logic               out_has_par_ff;
   logic [STAMP_W-1:0] out_disc_ff;
   logic [STAMP_W-1:0] out_fin_ff;
   logic               out_info_ff;
   logic               out_last_ff;

   logic [VID_W-1:0]   top_idx;
   logic [VID_W-1:0]   push_idx;
   logic [VID_W-1:0]   top_u;
   logic [CNT_W-1:0]   top_j;
   logic [VID_W-1:0]   j_idx;
   logic [VID_W-1:0]   root_idx;
   logic [STAMP_W-1:0] stamp;
   logic               scan_end;
   logic               edge_hit;
   logic               push_ok;
   logic               out_free;
   logic               rd_in_range;
   kind_type           kind;

   assign top_idx  = VID_W'(depth_ff - CNT_W'(1));
   assign push_idx = depth_ff[VID_W-1:0];
   assign top_u    = stk_vtx_ff[top_idx];
   assign top_j    = stk_nxt_ff[top_idx];
   assign j_idx    = top_j[VID_W-1:0];
   assign root_idx = root_ff[VID_W-1:0];
   assign stamp    = time_ff[STAMP_W-1:0];
   assign scan_end = (top_j >= VERTEX_COUNT);
   assign edge_hit = !scan_end && adj_ff[top_u][j_idx];
   assign push_ok  = (depth_ff < STACK_SLOTS);
   assign out_free = !out_valid_ff || rsp_ready;
   assign rd_in_range = ({1'b0, rd_vtx_ff} < VERTEX_COUNT);

   always_comb begin
      case (color_ff[j_idx])
         COLOR_UNSEEN: kind = KIND_TREE;
         COLOR_ACTIVE: kind = KIND_BACK;
         default: begin
            // A target finished before the source was discovered is a cross edge.
            kind = (fin_ff[j_idx] < disc_ff[top_u]) ? KIND_CROSS : KIND_FORWARD;
         end
      endcase
   end

   always_comb begin
      sts.roots_done  = (root_ff >= VERTEX_COUNT);
      sts.root_seen   = (color_ff[root_idx] != COLOR_UNSEEN);
      sts.stack_empty = (depth_ff == '0);
      sts.scan_end    = scan_end;
      sts.edge_hit    = edge_hit;
      sts.held_valid  = held_valid_ff;
      sts.out_free    = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            adj_ff[i]     <= '0;
            color_ff[i]   <= COLOR_UNSEEN;
            parent_ff[i]  <= '0;
            has_par_ff[i] <= 1'b0;
            disc_ff[i]    <= '0;
            fin_ff[i]     <= '0;
         end
         depth_ff      <= '0;
         root_ff       <= '0;
         time_ff       <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load_row && ({1'b0, req_vertex_index} < VERTEX_COUNT)) begin
            adj_ff[req_vertex_index] <= req_row_bits;
         end

         if (cmd.latch_read) begin
            rd_vtx_ff <= req_vertex_index;
         end

         if (cmd.start_run) begin
            for (int i = 0; i < SLOTS; i++) begin
               color_ff[i]   <= COLOR_UNSEEN;
               parent_ff[i]  <= '0;
               has_par_ff[i] <= 1'b0;
               disc_ff[i]    <= '0;
               fin_ff[i]     <= '0;
            end
            depth_ff      <= '0;
            root_ff       <= '0;
            time_ff       <= '0;
            held_valid_ff <= 1'b0;
         end

         if (cmd.root_skip) begin
            root_ff <= root_ff + CNT_W'(1);
         end

         if (cmd.root_push) begin
            root_ff            <= root_ff + CNT_W'(1);
            color_ff[root_idx] <= COLOR_ACTIVE;
            disc_ff[root_idx]  <= stamp;
            time_ff            <= time_ff + TIME_W'(1);
            if (push_ok) begin
               stk_vtx_ff[push_idx] <= root_idx;
               stk_nxt_ff[push_idx] <= '0;
               depth_ff             <= depth_ff + CNT_W'(1);
            end
         end

         if (cmd.pop) begin
            fin_ff[top_u]   <= stamp;
            color_ff[top_u] <= COLOR_DONE;
            time_ff         <= time_ff + TIME_W'(1);
            depth_ff        <= depth_ff - CNT_W'(1);
         end

         if (cmd.step) begin
            stk_nxt_ff[top_idx] <= top_j + CNT_W'(1);
            if (edge_hit) begin
               held_valid_ff <= 1'b1;
               held_from_ff  <= top_u;
               held_to_ff    <= j_idx;
               held_kind_ff  <= kind;
               if (kind == KIND_TREE) begin
                  color_ff[j_idx]   <= COLOR_ACTIVE;
                  parent_ff[j_idx]  <= top_u;
                  has_par_ff[j_idx] <= 1'b1;
                  disc_ff[j_idx]    <= stamp;
                  time_ff           <= time_ff + TIME_W'(1);
                  if (push_ok) begin
                     stk_vtx_ff[push_idx] <= j_idx;
                     stk_nxt_ff[push_idx] <= '0;
                     depth_ff             <= depth_ff + CNT_W'(1);
                  end
               end
            end
         end

         if (cmd.flush) begin
            held_valid_ff <= 1'b0;
         end

         // Output register: loaded with the held edge, the final edge or a read word.
         if ((cmd.step && edge_hit && held_valid_ff) || cmd.flush) begin
            out_valid_ff   <= 1'b1;
            out_from_ff    <= held_from_ff;
            out_to_ff      <= held_to_ff;
            out_kind_ff    <= held_kind_ff;
            out_parent_ff  <= '0;
            out_has_par_ff <= 1'b0;
            out_disc_ff    <= '0;
            out_fin_ff     <= '0;
            out_info_ff    <= 1'b0;
            out_last_ff    <= cmd.flush;
         end else if (cmd.read_emit) begin
            out_valid_ff   <= 1'b1;
            out_from_ff    <= rd_vtx_ff;
            out_to_ff      <= '0;
            out_kind_ff    <= KIND_TREE;
            out_parent_ff  <= (rd_in_range && has_par_ff[rd_vtx_ff]) ?
                              parent_ff[rd_vtx_ff] : '0;
            out_has_par_ff <= rd_in_range && has_par_ff[rd_vtx_ff];
            out_disc_ff    <= rd_in_range ? disc_ff[rd_vtx_ff] : '0;
            out_fin_ff     <= rd_in_range ? fin_ff[rd_vtx_ff] : '0;
            out_info_ff    <= 1'b1;
            out_last_ff    <= 1'b0;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_from_vertex    = out_from_ff;
   assign rsp_to_vertex      = out_to_ff;
   assign rsp_edge_kind      = out_kind_ff;
   assign rsp_parent_vertex  = out_parent_ff;
   assign rsp_has_parent     = out_has_par_ff;
   assign rsp_discover_time  = out_disc_ff;
   assign rsp_finish_time    = out_fin_ff;
   assign rsp_is_vertex_info = out_info_ff;
   assign rsp_last           = out_last_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/dfs_edge_classifier.sv
`default_nettype none
//------------------------------------------------------------------------------
// dfs_edge_classifier
// Depth-first search over a small directed graph with edge classification.
//------------------------------------------------------------------------------
// The block holds a VERTICES-by-VERTICES adjacency matrix that is loaded one row
// per request word. A run request clears all colors, parents and timestamps and
// walks the graph depth first, taking roots and neighbors in ascending order;
// every edge met leaves as one response word classed as tree, back, forward or
// cross, and the final edge word of a run carries last. A run over a graph with
// no edges returns nothing. A read request returns one response word with the
// vertex's parent and its discovery and finish times. A run is paced by the
// walk sequencer, which steps through each matrix cell, each root check, each
// vertex finish and each return to the root scan, besides accepting the run,
// seeing that the roots are done and releasing the final word. The walk holds
// while a new edge or the final word waits for the response side to take the
// previous word. Each edge word is held for one edge so that last can be set on
// it; the request side is ready again only when the run or read has finished.
//------------------------------------------------------------------------------
module dfs_edge_classifier
   import dfsec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dfsec_req_if.sink  req_chan,
   dfsec_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type sts;

   // The controller owns sequencing; it sees the datapath only through status.
   dfsec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the graph, the vertex records, the walk stack and the
   // output register that parts the response side from the walk.
   dfsec_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_vertex_index   (req_chan.vertex_index),
      .req_row_bits       (req_chan.row_bits),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_from_vertex    (rsp_chan.from_vertex),
      .rsp_to_vertex      (rsp_chan.to_vertex),
      .rsp_edge_kind      (rsp_chan.edge_kind),
      .rsp_parent_vertex  (rsp_chan.parent_vertex),
      .rsp_has_parent     (rsp_chan.has_parent),
      .rsp_discover_time  (rsp_chan.discover_time),
      .rsp_finish_time    (rsp_chan.finish_time),
      .rsp_is_vertex_info (rsp_chan.is_vertex_info),
      .rsp_last           (rsp_chan.last)
   );

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the depth-first edge classifier.
//------------------------------------------------------------------------------
// Request words are queued up front: a short directed list, then random graphs.
// The directed list covers reads before any search, an empty graph, the unused
// opcode, self-loops, full and empty rows, and every edge kind. Each random
// graph is loaded row by row at a random density, searched and probed with
// reads. Some sequences are noise or stop before the search. A clocked driver
// sends the words with random gaps. A clocked monitor stalls the response side
// at random. The bench keeps its own copy of the graph and the search state and
// predicts every response word when its request word is accepted. Each response
// word that arrives is checked field by field against the oldest prediction.
//------------------------------------------------------------------------------
module tb;
   import dfsec_pkg::*;

   localparam logic [3:0] NO_PARENT     = 4'b1000;
   localparam int         RANDOM_WORDS  = 200;
   localparam int         SETTLE_CYCLES = 200;
   localparam int         STALL_LIMIT   = 2000;

   typedef struct {
      op_type     op;
      logic [2:0] vertex_index;
      logic [7:0] row_bits;
      int         gap;
      bit         settle;
   } request_type;

   typedef struct {
      logic [2:0] from_vertex;
      logic [2:0] to_vertex;
      kind_type   edge_kind;
      logic [2:0] parent_vertex;
      logic       has_parent;
      logic [3:0] discover_time;
      logic [3:0] finish_time;
      logic       is_vertex_info;
      logic       last;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dfsec_req_if req_bus ();
   dfsec_rsp_if rsp_bus ();

   dfs_edge_classifier uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #6 clock = ~clock;

   // Words still to send and the response words that the accepted ones will cause.
   request_type     pending_requests[$];
   result_word_type expected_records[$];

   // Our own copy of the graph and of the search state.
   logic [7:0] adj_rows[8];
   color_type  vcolor[8];
   logic [3:0] parent_of[8];
   logic [3:0] disc_stamp[8];
   logic [3:0] fin_stamp[8];
   logic [4:0] stamp_clock;
   int         walk_vertex[8];
   int         walk_next[8];
   int         walk_depth;

   int  hold_off;
   int  ready_stall;
   bit  send_calm;
   bit  rsp_calm;
   int  counted;
   int  words_sent;
   int  runs_sent;
   int  reads_sent;
   int  records_checked;
   int  kind_count[4];
   int  mismatches;
   int  idle_cycles;

   function automatic result_word_type blank_word();
      result_word_type w;
      w.from_vertex    = '0;
      w.to_vertex      = '0;
      w.edge_kind      = KIND_TREE;
      w.parent_vertex  = '0;
      w.has_parent     = 1'b0;
      w.discover_time  = '0;
      w.finish_time    = '0;
      w.is_vertex_info = 1'b0;
      w.last           = 1'b0;
      return w;
   endfunction

   task automatic clear_search();
      for (int v = 0; v < 8; v++) begin
         vcolor[v]     = COLOR_UNSEEN;
         parent_of[v]  = NO_PARENT;
         disc_stamp[v] = '0;
         fin_stamp[v]  = '0;
      end
      stamp_clock = '0;
      walk_depth  = 0;
   endtask

   // Stamps the discovery time of a vertex and puts it on top of the walk.
   task automatic open_vertex(input int v);
      disc_stamp[v] = stamp_clock[3:0];
      stamp_clock++;
      if (walk_depth < 8) begin
         walk_vertex[walk_depth] = v;
         walk_next[walk_depth]   = 0;
         walk_depth++;
      end
   endtask

   // Depth-first walk: roots and neighbors in ascending order, one word per arc.
   task automatic classify_graph();
      result_word_type run_words[$];
      result_word_type w;
      int              top;
      int              u;
      int              j;
      clear_search();
      for (int r = 0; r < VERTICES; r++) begin
         if (vcolor[r] == COLOR_UNSEEN) begin
            vcolor[r] = COLOR_ACTIVE;
            open_vertex(r);
            while (walk_depth > 0) begin
               top = walk_depth - 1;
               u   = walk_vertex[top];
               j   = walk_next[top];
               if (j >= VERTICES) begin
                  // Every neighbor scanned: the vertex finishes.
                  fin_stamp[u] = stamp_clock[3:0];
                  stamp_clock++;
                  vcolor[u] = COLOR_DONE;
                  walk_depth--;
               end else begin
                  walk_next[top] = j + 1;
                  if (adj_rows[u][j]) begin
                     w             = blank_word();
                     w.from_vertex = 3'(u);
                     w.to_vertex   = 3'(j);
                     if (vcolor[j] == COLOR_UNSEEN) begin
                        w.edge_kind  = KIND_TREE;
                        vcolor[j]    = COLOR_ACTIVE;
                        parent_of[j] = {1'b0, 3'(u)};
                        open_vertex(j);
                     end else if (vcolor[j] == COLOR_ACTIVE) begin
                        // An ancestor on the walk, which includes a self-loop.
                        w.edge_kind = KIND_BACK;
                     end else if (fin_stamp[j] < disc_stamp[u]) begin
                        w.edge_kind = KIND_CROSS;
                     end else begin
                        w.edge_kind = KIND_FORWARD;
                     end
                     run_words.push_back(w);
                  end
               end
            end
         end
      end
      if (run_words.size() > 0) begin
         run_words[run_words.size() - 1].last = 1'b1;
      end
      foreach (run_words[k]) begin
         expected_records.push_back(run_words[k]);
      end
   endtask

   task automatic predict_word(input op_type op, input logic [2:0] idx,
                               input logic [7:0] bits);
      result_word_type w;
      case (op)
         OP_LOAD: begin
            if (idx < VERTICES) begin
               adj_rows[idx] = bits;
            end
         end
         OP_RUN: begin
            runs_sent++;
            classify_graph();
         end
         OP_READ: begin
            reads_sent++;
            w                = blank_word();
            w.from_vertex    = idx;
            w.is_vertex_info = 1'b1;
            if (idx < VERTICES) begin
               if (parent_of[idx][3] == 1'b0) begin
                  w.parent_vertex = parent_of[idx][2:0];
                  w.has_parent    = 1'b1;
               end
               w.discover_time = disc_stamp[idx];
               w.finish_time   = fin_stamp[idx];
            end
            expected_records.push_back(w);
         end
         default: begin
         end
      endcase
   endtask

   task automatic queue_word(input op_type op, input int idx, input int bits,
                             input bit settle);
      request_type item;
      item.op           = op;
      item.vertex_index = 3'(idx);
      item.row_bits     = 8'(bits);
      item.gap          = send_calm ? 0 : $urandom_range(0, 10);
      item.settle       = settle;
      pending_requests.push_back(item);
      if (op != OP_NONE) begin
         counted++;
      end
   endtask

   task automatic compare_field(input string name, input logic [3:0] want,
                                input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Request driver. The valid level is settled in a variable first so that it
   // gets exactly one nonblocking write per edge. A word marked settle is held
   // back until every predicted response word has arrived.
   always @(posedge clock) begin : request_driver
      request_type nxt;
      logic        drive_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
         hold_off      <= 0;
         for (int v = 0; v < 8; v++) begin
            adj_rows[v] = '0;
         end
         clear_search();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_word(op_type'(req_bus.op), req_bus.vertex_index, req_bus.row_bits);
            words_sent++;
         end
         drive_valid = req_bus.valid && !req_bus.ready;
         if (!drive_valid) begin
            if (hold_off > 0) begin
               hold_off <= hold_off - 1;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].settle && expected_records.size() > 0)) begin
               nxt                  = pending_requests.pop_front();
               req_bus.op           <= nxt.op;
               req_bus.vertex_index <= nxt.vertex_index;
               req_bus.row_bits     <= nxt.row_bits;
               hold_off             <= nxt.gap;
               drive_valid          = 1'b1;
            end
         end
         req_bus.valid <= drive_valid;
      end
   end

   // Response monitor. Ready drops for a random number of valid cycles after
   // each word, with occasional stretches in which it never drops.
   always @(posedge clock) begin : result_monitor
      result_word_type want;
      int              stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_stall   <= 0;
      end else begin
         stall = ready_stall;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_records.size() == 0) begin
               $display("%0t: response word with nothing expected, from %0d to %0d",
                        $time, rsp_bus.from_vertex, rsp_bus.to_vertex);
               mismatches++;
            end else begin
               want = expected_records.pop_front();
               compare_field("from_vertex", want.from_vertex, rsp_bus.from_vertex);
               compare_field("to_vertex", want.to_vertex, rsp_bus.to_vertex);
               compare_field("edge_kind", want.edge_kind, rsp_bus.edge_kind);
               compare_field("parent_vertex", want.parent_vertex, rsp_bus.parent_vertex);
               compare_field("has_parent", want.has_parent, rsp_bus.has_parent);
               compare_field("discover_time", want.discover_time, rsp_bus.discover_time);
               compare_field("finish_time", want.finish_time, rsp_bus.finish_time);
               compare_field("is_vertex_info", want.is_vertex_info, rsp_bus.is_vertex_info);
               compare_field("last", want.last, rsp_bus.last);
               if (!want.is_vertex_info) begin
                  kind_count[want.edge_kind]++;
               end
               records_checked++;
            end
            if ($urandom_range(0, 31) == 0) begin
               rsp_calm = !rsp_calm;
            end
            stall = rsp_calm ? 0 : $urandom_range(0, 10);
         end else if (stall > 0 && rsp_bus.valid) begin
            stall--;
         end
         ready_stall   <= stall;
         rsp_bus.ready <= (stall == 0);
      end
   end

   // Watchdog: cycles in a row in which neither side moves a word.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int         density;
      int         flavor;
      logic [7:0] bits;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_NONE;
      req_bus.vertex_index = '0;
      req_bus.row_bits     = '0;
      rsp_bus.ready        = 1'b0;
      idle_cycles          = 0;
      send_calm            = 1'b0;
      rsp_calm             = 1'b0;

      // Directed part. Reads before any search return the reset values, and a
      // search over an empty graph returns nothing.
      queue_word(OP_READ, 0, 0, 0);
      queue_word(OP_READ, 7, 8'hFF, 0);
      queue_word(OP_RUN, 0, 0, 0);
      queue_word(OP_NONE, 5, 8'hAA, 0);
      // Vertex 0 has a self-loop, a tree arc to 1 and a forward arc to 2; 2 closes
      // a cycle back to 0; 3 reaches into the finished tree with a cross arc; the
      // full row on 7 gives cross arcs to everything below it and a self-loop.
      queue_word(OP_LOAD, 0, 8'h07, 0);
      queue_word(OP_LOAD, 1, 8'h04, 0);
      queue_word(OP_LOAD, 2, 8'h01, 0);
      queue_word(OP_LOAD, 3, 8'h02, 0);
      queue_word(OP_LOAD, 4, 8'h00, 0);
      queue_word(OP_LOAD, 7, 8'hFF, 0);
      queue_word(OP_RUN, 0, 0, 0);
      // The sender holds this read until the whole search has come back.
      queue_word(OP_READ, 0, 0, 1);
      queue_word(OP_READ, 2, 0, 0);
      queue_word(OP_READ, 3, 0, 0);
      queue_word(OP_READ, 7, 0, 0);
      queue_word(OP_LOAD, 5, 8'hFF, 0);
      queue_word(OP_LOAD, 6, 8'h80, 0);
      queue_word(OP_RUN, 0, 0, 0);
      queue_word(OP_READ, 5, 0, 0);
      queue_word(OP_READ, 6, 0, 0);
      queue_word(OP_NONE, 0, 0, 0);

      // Random part: mostly whole graphs with a search and reads, some noise,
      // and some loads that never reach a search.
      while (counted < RANDOM_WORDS) begin
         send_calm = ($urandom_range(0, 4) == 0);
         flavor    = $urandom_range(0, 9);
         if (flavor == 0) begin
            queue_word(op_type'($urandom_range(0, 3)), $urandom_range(0, 7),
                       $urandom_range(0, 255), 0);
         end else if (flavor == 1) begin
            repeat ($urandom_range(1, 3)) begin
               queue_word(OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 255), 0);
            end
            queue_word(OP_READ, $urandom_range(0, 7), $urandom_range(0, 255), 0);
         end else begin
            density = $urandom_range(0, 8);
            for (int r = 0; r < 8; r++) begin
               if ($urandom_range(0, 7) != 0) begin
                  for (int b = 0; b < 8; b++) begin
                     bits[b] = ($urandom_range(0, 7) < density);
                  end
                  queue_word(OP_LOAD, r, bits, 0);
               end
            end
            queue_word(OP_RUN, $urandom_range(0, 7), $urandom_range(0, 255),
                       $urandom_range(0, 7) == 0);
            repeat ($urandom_range(1, 3)) begin
               queue_word(OP_READ, $urandom_range(0, 7), $urandom_range(0, 255),
                          $urandom_range(0, 15) == 0);
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_bus.valid) @(posedge clock);
      while (expected_records.size() > 0) @(posedge clock);
      // A search over a graph without arcs may still be walking here.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request words, among them %0d searches and %0d reads.",
               words_sent, runs_sent, reads_sent);
      $display("Checked %0d response words: %0d tree, %0d back, %0d forward, %0d cross.",
               records_checked, kind_count[KIND_TREE], kind_count[KIND_BACK],
               kind_count[KIND_FORWARD], kind_count[KIND_CROSS]);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/dfsec_pkg.sv
hw/rtl/dfsec_req_if.sv
hw/rtl/dfsec_rsp_if.sv
hw/rtl/dfsec_ctrl.sv
hw/rtl/dfsec_datapath.sv
hw/rtl/dfs_edge_classifier.sv
test/tb.sv
